>>> rtl/char_lcd_4bit_write_controller_top_macros.svh
`ifndef CHAR_LCD_4BIT_WRITE_CONTROLLER_TOP_MACROS_SVH
`define CHAR_LCD_4BIT_WRITE_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CLCD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CLCD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/clcd_pkg.sv
`default_nettype none
package clcd_pkg;

	localparam int COUNT_W = 20;
	localparam int CFG_IDX_W = 3;
	localparam logic [3:0] INIT_STEPS = 4'd9;
	localparam logic [3:0] FIRST_BYTE_STEP = 4'd4;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_CMD  = 2'd1,
		MODE_CHAR = 2'd2,
		MODE_INIT = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_SETTLE = 3'd1,
		PH_ENABLE = 3'd2,
		PH_GAP    = 3'd3,
		PH_POST   = 3'd4
	} phase_t;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE_HIGH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NIBBLE_GAP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WAKE_WAIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CMD_WAIT    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_WAIT  = 3'd5;

	typedef struct packed {
		logic [COUNT_W-1:0] enable_high_ticks;
		logic [COUNT_W-1:0] nibble_gap_ticks;
		logic [COUNT_W-1:0] settle_ticks;
		logic [COUNT_W-1:0] wake_wait_ticks;
		logic [COUNT_W-1:0] command_wait_ticks;
		logic [COUNT_W-1:0] clear_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic       pin_enable;
		logic       pin_select;
		logic       pin_readwrite;
		logic [3:0] data_nibble;
		logic       backlight;
		logic       busy_res;
		logic       rejected;
	} res_t;

	// A zero count behaves as a single tick.
	function automatic logic [COUNT_W-1:0] count_load(input logic [COUNT_W-1:0] r);
		count_load = (r == '0) ? COUNT_W'(1) : r;
	endfunction

	// Byte sent at each step of the power-up program.
	function automatic logic [7:0] init_value(input logic [3:0] step);
		case (step)
			4'd0, 4'd1, 4'd2: init_value = 8'h03;
			4'd3:             init_value = 8'h02;
			4'd4:             init_value = 8'h28;
			4'd5:             init_value = 8'h10;
			4'd6:             init_value = 8'h06;
			4'd7:             init_value = 8'h0E;
			default:          init_value = 8'h01;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> rtl/clcd_in_if.sv
`default_nettype none
interface clcd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface
`default_nettype wire

>>> rtl/clcd_out_if.sv
`default_nettype none
interface clcd_out_if;
	logic       valid;
	logic       ready;
	logic       pin_enable;
	logic       pin_select;
	logic       pin_readwrite;
	logic [3:0] data_nibble;
	logic       backlight;
	logic       busy_res;
	logic       rejected;

	modport source (output valid, output pin_enable, output pin_select, output pin_readwrite,
		output data_nibble, output backlight, output busy_res, output rejected, input ready);
	modport sink (input valid, input pin_enable, input pin_select, input pin_readwrite,
		input data_nibble, input backlight, input busy_res, input rejected, output ready);
endinterface
`default_nettype wire

>>> rtl/char_lcd_4bit_write_controller_top.sv
// Channel   Dir  Payload                                              Transfer rule
// in        in   mode[1:0], value[7:0]                                valid & ready
// out       out  pin_enable, pin_select, pin_readwrite, data_nibble,  valid & ready
//                backlight, busy_res, rejected
// cfg       in   cfg_index[2:0], cfg_wdata[19:0]                      cfg_we
//
// The block takes one item per clock cycle while the output is not stalled, and returns one result per item,
// registered first in the input stage and then in the result register.
// The state update for a tick is a single decrement and compare of the 20-bit tick counter.
// arst_n clears the controller state, the valid flags and loads the register defaults.
// A stalled output fills the result register and then the input stage before in.ready drops.
`default_nettype none
module char_lcd_4bit_write_controller_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	clcd_in_if.sink                                    in,
	clcd_out_if.source                                 out,
	input  wire logic                                  cfg_we,
	input  wire logic [clcd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [clcd_pkg::COUNT_W-1:0]          cfg_wdata
);

	// Timing registers. The user must write them only while the controller is idle; the
	// block does not enforce this, and the core reads them directly without any shadow copy.
	clcd_pkg::cfg_t cfg_q;

	// Result register on the output side. The core only produces a result when
	// this register is empty or is being emptied in the same cycle.
	logic           out_valid_q;
	clcd_pkg::res_t out_data_q;
	logic           out_space;
	logic           res_valid;
	clcd_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable_high_ticks  <= clcd_pkg::COUNT_W'(1);
			cfg_q.nibble_gap_ticks   <= clcd_pkg::COUNT_W'(160);
			cfg_q.settle_ticks       <= clcd_pkg::COUNT_W'(500000);
			cfg_q.wake_wait_ticks    <= clcd_pkg::COUNT_W'(5000);
			cfg_q.command_wait_ticks <= clcd_pkg::COUNT_W'(160);
			cfg_q.clear_wait_ticks   <= clcd_pkg::COUNT_W'(40000);
		end else if (cfg_we) begin
			// Indexes past the last register are ignored.
			case (cfg_index)
				clcd_pkg::REG_ENABLE_HIGH: cfg_q.enable_high_ticks  <= cfg_wdata;
				clcd_pkg::REG_NIBBLE_GAP:  cfg_q.nibble_gap_ticks   <= cfg_wdata;
				clcd_pkg::REG_SETTLE:      cfg_q.settle_ticks       <= cfg_wdata;
				clcd_pkg::REG_WAKE_WAIT:   cfg_q.wake_wait_ticks    <= cfg_wdata;
				clcd_pkg::REG_CMD_WAIT:    cfg_q.command_wait_ticks <= cfg_wdata;
				clcd_pkg::REG_CLEAR_WAIT:  cfg_q.clear_wait_ticks   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign out_space = !out_valid_q || out.ready;

	// The core holds the input stage and the whole controller state; each
	// accepted item updates the state once, in order, and yields one result.
	clcd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in        (in),
		.cfg       (cfg_q),
		.out_space (out_space),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_data_q <= res;
		end
	end

	assign out.valid         = out_valid_q;
	assign out.pin_enable    = out_data_q.pin_enable;
	assign out.pin_select    = out_data_q.pin_select;
	assign out.pin_readwrite = out_data_q.pin_readwrite;
	assign out.data_nibble   = out_data_q.data_nibble;
	assign out.backlight     = out_data_q.backlight;
	assign out.busy_res      = out_data_q.busy_res;
	assign out.rejected      = out_data_q.rejected;

endmodule
`default_nettype wire

>>> rtl/clcd_core.sv
`default_nettype none
`include "char_lcd_4bit_write_controller_top_macros.svh"
module clcd_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	clcd_in_if.sink            in,
	input  wire clcd_pkg::cfg_t cfg,
	input  wire logic          out_space,
	output logic               res_valid,
	output clcd_pkg::res_t     res
);

	logic                         valid_s1;
	logic [1:0]                   mode_s1;
	logic [7:0]                   value_s1;
	logic                         fire;

	clcd_pkg::phase_t             phase_q, phase_n;
	logic [clcd_pkg::COUNT_W-1:0] wait_q, wait_n, wait_dec;
	logic [7:0]                   held_q, held_n;
	logic                         low_q, low_n;
	logic                         sel_q, sel_n;
	logic [3:0]                   step_q, step_n, step_inc;
	logic                         init_q, init_n;
	logic                         light_q, light_n;
	logic                         busy, rej;

	assign fire      = valid_s1 && out_space;
	assign in.ready  = !valid_s1 || fire;
	assign res_valid = fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in.valid && in.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in.valid && in.ready) begin
			mode_s1  <= in.mode;
			value_s1 <= in.value;
		end
	end

	assign busy     = (phase_q inside {clcd_pkg::PH_SETTLE, clcd_pkg::PH_ENABLE,
		clcd_pkg::PH_GAP, clcd_pkg::PH_POST});
	assign wait_dec = wait_q - clcd_pkg::COUNT_W'(1);
	assign step_inc = step_q + 4'd1;

	always_comb begin
		phase_n = phase_q;
		wait_n  = wait_q;
		held_n  = held_q;
		low_n   = low_q;
		sel_n   = sel_q;
		step_n  = step_q;
		init_n  = init_q;
		light_n = light_q;
		rej     = 1'b0;
		if (clcd_pkg::mode_t'(mode_s1) == clcd_pkg::MODE_TICK) begin
			if (!busy) begin
				phase_n = clcd_pkg::PH_IDLE;
			end else if (wait_dec != '0) begin
				wait_n = wait_dec;
			end else begin
				wait_n = wait_dec;
				case (phase_q)
					clcd_pkg::PH_SETTLE: begin
						step_n  = 4'd0;
						held_n  = clcd_pkg::init_value(4'd0);
						low_n   = 1'b0;
						sel_n   = 1'b0;
						phase_n = clcd_pkg::PH_ENABLE;
						wait_n  = clcd_pkg::count_load(cfg.enable_high_ticks);
					end
					clcd_pkg::PH_ENABLE: begin
						phase_n = clcd_pkg::PH_GAP;
						wait_n  = clcd_pkg::count_load(cfg.nibble_gap_ticks);
					end
					clcd_pkg::PH_GAP: begin
						if (low_q) begin
							low_n   = 1'b0;
							phase_n = clcd_pkg::PH_ENABLE;
							wait_n  = clcd_pkg::count_load(cfg.enable_high_ticks);
						end else if (init_q) begin
							phase_n = clcd_pkg::PH_POST;
							if (step_q == 4'd0) begin
								wait_n = clcd_pkg::count_load(cfg.wake_wait_ticks);
							end else if (step_q >= clcd_pkg::INIT_STEPS - 4'd1) begin
								wait_n = clcd_pkg::count_load(cfg.clear_wait_ticks);
							end else begin
								wait_n = clcd_pkg::count_load(cfg.command_wait_ticks);
							end
						end else begin
							phase_n = clcd_pkg::PH_IDLE;
						end
					end
					clcd_pkg::PH_POST: begin
						step_n = step_inc;
						if (step_inc >= clcd_pkg::INIT_STEPS) begin
							light_n = 1'b1;
							init_n  = 1'b0;
							phase_n = clcd_pkg::PH_IDLE;
						end else begin
							held_n  = clcd_pkg::init_value(step_inc);
							low_n   = (step_inc >= clcd_pkg::FIRST_BYTE_STEP);
							sel_n   = 1'b0;
							phase_n = clcd_pkg::PH_ENABLE;
							wait_n  = clcd_pkg::count_load(cfg.enable_high_ticks);
						end
					end
					default: begin
						phase_n = clcd_pkg::PH_IDLE;
					end
				endcase
			end
		end else if (busy) begin
			rej = 1'b1;
		end else if (clcd_pkg::mode_t'(mode_s1) == clcd_pkg::MODE_INIT) begin
			init_n  = 1'b1;
			step_n  = 4'd0;
			held_n  = 8'h00;
			low_n   = 1'b0;
			sel_n   = 1'b0;
			phase_n = clcd_pkg::PH_SETTLE;
			wait_n  = clcd_pkg::count_load(cfg.settle_ticks);
		end else begin
			held_n  = value_s1;
			low_n   = 1'b1;
			sel_n   = (clcd_pkg::mode_t'(mode_s1) == clcd_pkg::MODE_CHAR);
			phase_n = clcd_pkg::PH_ENABLE;
			wait_n  = clcd_pkg::count_load(cfg.enable_high_ticks);
		end
	end

	always_comb begin
		res.pin_enable    = (phase_n == clcd_pkg::PH_ENABLE);
		res.pin_select    = sel_n;
		res.pin_readwrite = 1'b0;
		res.data_nibble   = low_n ? held_n[7:4] : held_n[3:0];
		res.backlight     = light_n;
		res.busy_res      = (phase_n inside {clcd_pkg::PH_SETTLE, clcd_pkg::PH_ENABLE,
			clcd_pkg::PH_GAP, clcd_pkg::PH_POST});
		res.rejected      = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= clcd_pkg::PH_IDLE;
			wait_q  <= '0;
			held_q  <= 8'h00;
			low_q   <= 1'b0;
			sel_q   <= 1'b0;
			step_q  <= 4'd0;
			init_q  <= 1'b0;
			light_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			wait_q  <= wait_n;
			held_q  <= held_n;
			low_q   <= low_n;
			sel_q   <= sel_n;
			step_q  <= step_n;
			init_q  <= init_n;
			light_q <= light_n;
		end
	end

	`CLCD_ASSERT_NEXT(a_byte_starts, clk, arst_n,
		fire && !busy && (mode_s1 == clcd_pkg::MODE_CMD || mode_s1 == clcd_pkg::MODE_CHAR),
		phase_q == clcd_pkg::PH_ENABLE && low_q, "byte request did not raise enable")
	`CLCD_ASSERT_NEXT(a_init_starts, clk, arst_n,
		fire && !busy && mode_s1 == clcd_pkg::MODE_INIT,
		phase_q == clcd_pkg::PH_SETTLE && init_q, "init request did not start settle wait")
	`CLCD_ASSERT_NEXT(a_light_stays, clk, arst_n, light_q, light_q,
		"backlight switched off")
	`CLCD_ASSERT_NOW(a_init_phases, clk, arst_n,
		phase_q == clcd_pkg::PH_SETTLE || phase_q == clcd_pkg::PH_POST, init_q,
		"init-only phase reached outside initialization")

endmodule
`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 100ps

// Tracks the controller state for every accepted input transfer and keeps the
// pin levels that each one must produce, oldest first.
class lcd_pin_scoreboard;
	logic [clcd_pkg::COUNT_W-1:0] regs [6];

	clcd_pkg::phase_t ph;
	logic [clcd_pkg::COUNT_W-1:0] ticks_left;
	logic [7:0] byte_q;
	logic [3:0] init_idx;
	bit low_pending;
	bit rs;
	bit in_init;
	bit light;

	clcd_pkg::res_t pins_due [$];
	int errors;
	int n_in;
	int n_out;
	int n_rej;
	int n_init_done;

	function new();
		regs[clcd_pkg::REG_ENABLE_HIGH] = 20'd1;
		regs[clcd_pkg::REG_NIBBLE_GAP] = 20'd160;
		regs[clcd_pkg::REG_SETTLE] = 20'd500000;
		regs[clcd_pkg::REG_WAKE_WAIT] = 20'd5000;
		regs[clcd_pkg::REG_CMD_WAIT] = 20'd160;
		regs[clcd_pkg::REG_CLEAR_WAIT] = 20'd40000;
		ph = clcd_pkg::PH_IDLE;
		ticks_left = '0;
		byte_q = '0;
		init_idx = '0;
		low_pending = 0;
		rs = 0;
		in_init = 0;
		light = 0;
		errors = 0;
		n_in = 0;
		n_out = 0;
		n_rej = 0;
		n_init_done = 0;
	endfunction

	function void set_reg(logic [clcd_pkg::CFG_IDX_W-1:0] idx,
		logic [clcd_pkg::COUNT_W-1:0] val);
		regs[idx] = val;
	endfunction

	function int pending();
		return pins_due.size();
	endfunction

	function bit busy();
		return ph >= clcd_pkg::PH_SETTLE && ph <= clcd_pkg::PH_POST;
	endfunction

	// A register holding zero still waits one tick.
	function logic [clcd_pkg::COUNT_W-1:0] ticks_for(logic [clcd_pkg::COUNT_W-1:0] r);
		return (r == '0) ? clcd_pkg::COUNT_W'(1) : r;
	endfunction

	function logic [7:0] program_byte(logic [3:0] idx);
		case (idx)
			4'd0, 4'd1, 4'd2: return 8'h03;
			4'd3: return 8'h02;
			4'd4: return 8'h28;
			4'd5: return 8'h10;
			4'd6: return 8'h06;
			4'd7: return 8'h0E;
			default: return 8'h01;
		endcase
	endfunction

	function void raise_strobe();
		ph = clcd_pkg::PH_ENABLE;
		ticks_left = ticks_for(regs[clcd_pkg::REG_ENABLE_HIGH]);
	endfunction

	function void load_program_step();
		logic [3:0] s;
		s = (init_idx >= clcd_pkg::INIT_STEPS) ? clcd_pkg::INIT_STEPS - 4'd1 : init_idx;
		byte_q = program_byte(s);
		// The wake-up steps send a single nibble, the commands a whole byte.
		low_pending = (s >= clcd_pkg::FIRST_BYTE_STEP);
		rs = 0;
		raise_strobe();
	endfunction

	function void wait_expired();
		logic [clcd_pkg::COUNT_W-1:0] w;
		case (ph)
			clcd_pkg::PH_SETTLE: begin
				init_idx = '0;
				load_program_step();
			end
			clcd_pkg::PH_ENABLE: begin
				ph = clcd_pkg::PH_GAP;
				ticks_left = ticks_for(regs[clcd_pkg::REG_NIBBLE_GAP]);
			end
			clcd_pkg::PH_GAP: begin
				if (low_pending) begin
					low_pending = 0;
					raise_strobe();
				end else if (in_init) begin
					if (init_idx == '0)
						w = regs[clcd_pkg::REG_WAKE_WAIT];
					else if (init_idx >= clcd_pkg::INIT_STEPS - 4'd1)
						w = regs[clcd_pkg::REG_CLEAR_WAIT];
					else
						w = regs[clcd_pkg::REG_CMD_WAIT];
					ph = clcd_pkg::PH_POST;
					ticks_left = ticks_for(w);
				end else begin
					ph = clcd_pkg::PH_IDLE;
				end
			end
			clcd_pkg::PH_POST: begin
				init_idx = init_idx + 4'd1;
				if (init_idx >= clcd_pkg::INIT_STEPS) begin
					light = 1;
					in_init = 0;
					ph = clcd_pkg::PH_IDLE;
					n_init_done++;
				end else begin
					load_program_step();
				end
			end
			default: ph = clcd_pkg::PH_IDLE;
		endcase
	endfunction

	function void predict_pins(clcd_pkg::mode_t m, logic [7:0] v);
		clcd_pkg::res_t want;
		bit was_busy;
		bit rej;
		was_busy = busy();
		rej = 0;
		n_in++;
		if (m == clcd_pkg::MODE_TICK) begin
			if (was_busy) begin
				ticks_left = ticks_left - 1'b1;
				if (ticks_left == '0)
					wait_expired();
			end else begin
				ph = clcd_pkg::PH_IDLE;
			end
		end else if (was_busy) begin
			rej = 1;
			n_rej++;
		end else if (m == clcd_pkg::MODE_INIT) begin
			in_init = 1;
			init_idx = '0;
			byte_q = '0;
			low_pending = 0;
			rs = 0;
			ph = clcd_pkg::PH_SETTLE;
			ticks_left = ticks_for(regs[clcd_pkg::REG_SETTLE]);
		end else begin
			byte_q = v;
			low_pending = 1;
			rs = (m == clcd_pkg::MODE_CHAR);
			raise_strobe();
		end
		want.pin_enable = (ph == clcd_pkg::PH_ENABLE);
		want.pin_select = rs;
		want.pin_readwrite = 1'b0;
		want.data_nibble = low_pending ? byte_q[7:4] : byte_q[3:0];
		want.backlight = light;
		want.busy_res = busy();
		want.rejected = rej;
		pins_due.push_back(want);
	endfunction

	task report(string what, logic [3:0] got, logic [3:0] want);
		errors++;
		$display("%0d ns: %s mismatch, got %0h, expected %0h", $time, what, got, want);
	endtask

	task check_pins(clcd_pkg::res_t got);
		clcd_pkg::res_t want;
		n_out++;
		if (pins_due.size() == 0) begin
			report("result with no request waiting", 4'd0, 4'd0);
		end else begin
			want = pins_due.pop_front();
			if (got.pin_enable !== want.pin_enable)
				report("pin_enable", got.pin_enable, want.pin_enable);
			if (got.pin_select !== want.pin_select)
				report("pin_select", got.pin_select, want.pin_select);
			if (got.pin_readwrite !== want.pin_readwrite)
				report("pin_readwrite", got.pin_readwrite, want.pin_readwrite);
			if (got.data_nibble !== want.data_nibble)
				report("data_nibble", got.data_nibble, want.data_nibble);
			if (got.backlight !== want.backlight)
				report("backlight", got.backlight, want.backlight);
			if (got.busy_res !== want.busy_res)
				report("busy_res", got.busy_res, want.busy_res);
			if (got.rejected !== want.rejected)
				report("rejected", got.rejected, want.rejected);
		end
	endtask
endclass

module tb;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [clcd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [clcd_pkg::COUNT_W-1:0] cfg_wdata;

	// Percentages of cycles in which the sender idles and the receiver stalls.
	int tx_idle_pct;
	int rx_stall_pct;
	// Set by the main sequence to ask for one long output hold-off.
	int hold_request;
	int hold_left;

	lcd_pin_scoreboard sb;

	clcd_in_if in_ch ();
	clcd_out_if out_ch ();

	char_lcd_4bit_write_controller_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_ch),
		.out(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// The receiver decides ready at each falling edge. A requested hold-off is
	// counted down here, one cycle at a time, while the sender keeps offering
	// items, so the result register and the input stage both fill up.
	initial begin
		out_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left != 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		clcd_pkg::res_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.pin_enable, out_ch.pin_select, out_ch.pin_readwrite,
				out_ch.data_nibble, out_ch.backlight, out_ch.busy_res, out_ch.rejected};
			sb.check_pins(got);
		end
	end

	// Offers one item, starting at a falling edge, and returns at the falling
	// edge after its transfer. The expectation is formed at the transfer edge, so
	// the predictor is current when the next item is chosen.
	task automatic send_item(input clcd_pkg::mode_t m, input logic [7:0] v);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= m;
		in_ch.value <= v;
		do
			@(posedge clk);
		while (!in_ch.ready);
		sb.predict_pins(m, v);
		@(negedge clk);
	endtask

	// Drops valid and waits until every expected result has been transferred.
	// Time always advances, so a following valid never lands in the same step.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [clcd_pkg::CFG_IDX_W-1:0] idx,
		input logic [clcd_pkg::COUNT_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
	endtask

	// Writes all six timing registers back to back once the pipeline is empty.
	task automatic program_regs(input logic [clcd_pkg::COUNT_W-1:0] en_t,
		input logic [clcd_pkg::COUNT_W-1:0] gap_t,
		input logic [clcd_pkg::COUNT_W-1:0] settle_t,
		input logic [clcd_pkg::COUNT_W-1:0] wake_t,
		input logic [clcd_pkg::COUNT_W-1:0] cmd_t,
		input logic [clcd_pkg::COUNT_W-1:0] clr_t);
		wait_drained();
		write_reg(clcd_pkg::REG_ENABLE_HIGH, en_t);
		write_reg(clcd_pkg::REG_NIBBLE_GAP, gap_t);
		write_reg(clcd_pkg::REG_SETTLE, settle_t);
		write_reg(clcd_pkg::REG_WAKE_WAIT, wake_t);
		write_reg(clcd_pkg::REG_CMD_WAIT, cmd_t);
		write_reg(clcd_pkg::REG_CLEAR_WAIT, clr_t);
		cfg_we <= 1'b0;
	endtask

	// Short timings keep a whole power-up program to a few dozen ticks. Zero
	// is allowed on the wait registers to hit the one-tick floor.
	task automatic program_small_regs();
		program_regs(clcd_pkg::COUNT_W'($urandom_range(3, 1)),
			clcd_pkg::COUNT_W'($urandom_range(5, 1)),
			clcd_pkg::COUNT_W'($urandom_range(10, 1)),
			clcd_pkg::COUNT_W'($urandom_range(6, 0)),
			clcd_pkg::COUNT_W'($urandom_range(4, 0)),
			clcd_pkg::COUNT_W'($urandom_range(12, 0)));
	endtask

	// Mostly well-formed traffic: ticks while the controller works, a request
	// once it is free, and now and then a request that arrives too early and
	// must be rejected. Ticks while idle do nothing and are not counted.
	task automatic run_random(input int count);
		int done;
		int r;
		clcd_pkg::mode_t m;
		done = 0;
		while (done < count) begin
			r = $urandom_range(99);
			if (sb.busy()) begin
				m = (r < 88) ? clcd_pkg::MODE_TICK : clcd_pkg::mode_t'($urandom_range(3, 1));
			end else if (r < 10) begin
				m = clcd_pkg::MODE_TICK;
			end else if (r < 50) begin
				m = clcd_pkg::MODE_CMD;
			end else if (r < 82) begin
				m = clcd_pkg::MODE_CHAR;
			end else begin
				m = clcd_pkg::MODE_INIT;
			end
			if (m != clcd_pkg::MODE_TICK || sb.busy())
				done++;
			send_item(m, 8'($urandom_range(255)));
		end
	endtask

	// The run is far shorter than this in every correct case.
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		sb = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = clcd_pkg::MODE_TICK;
		in_ch.value = '0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_request = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. Zero in the strobe and wake registers must behave as a
		// single tick; the nibble gap is kept minimal so each byte takes four ticks.
		program_regs(20'd0, 20'd1, 20'd2, 20'd0, 20'd1, 20'd3);
		send_item(clcd_pkg::MODE_TICK, 8'h00);
		// Command byte with all bits low, walked through both nibbles to idle.
		send_item(clcd_pkg::MODE_CMD, 8'h00);
		repeat (4) send_item(clcd_pkg::MODE_TICK, 8'h00);
		// Character byte with all bits high, with a command refused while busy.
		send_item(clcd_pkg::MODE_CHAR, 8'hFF);
		send_item(clcd_pkg::MODE_CMD, 8'h3C);
		repeat (4) send_item(clcd_pkg::MODE_TICK, 8'hFF);
		// A mixed byte; both a character and an init request are refused.
		send_item(clcd_pkg::MODE_CMD, 8'hA5);
		send_item(clcd_pkg::MODE_CHAR, 8'h5A);
		send_item(clcd_pkg::MODE_INIT, 8'h00);
		repeat (4) send_item(clcd_pkg::MODE_TICK, 8'h00);
		// Start the power-up program; the first request after it is refused and
		// the random part below ticks it through to the backlight.
		send_item(clcd_pkg::MODE_INIT, 8'hC3);
		send_item(clcd_pkg::MODE_TICK, 8'h00);
		send_item(clcd_pkg::MODE_CHAR, 8'h41);

		// No idling. After a run on the directed timings, every timing goes to its smallest
		// nonzero value; halfway through the sender stops until every result has come back.
		run_random(180);
		program_regs(20'd1, 20'd1, 20'd1, 20'd1, 20'd1, 20'd1);
		run_random(90);
		wait_drained();
		run_random(90);

		// Sender idles in about half the cycles.
		program_small_regs();
		tx_idle_pct = 47;
		run_random(360);

		// Receiver stalls in about half the cycles, opening with a long hold-off
		// while the sender keeps pushing, so the input side backs up.
		program_small_regs();
		tx_idle_pct = 0;
		rx_stall_pct = 47;
		hold_request = 200;
		run_random(360);

		// Both sides idle now and then.
		program_small_regs();
		tx_idle_pct = 15;
		rx_stall_pct = 15;
		run_random(360);

		// Every register at its 20-bit maximum. The settle wait alone outlasts
		// the run, so every later request is refused.
		program_regs(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		send_item(clcd_pkg::MODE_INIT, 8'h00);
		repeat (6) send_item(clcd_pkg::MODE_TICK, 8'h00);
		send_item(clcd_pkg::MODE_CMD, 8'h01);
		send_item(clcd_pkg::MODE_CHAR, 8'h7E);
		send_item(clcd_pkg::MODE_INIT, 8'hFF);
		repeat (6) send_item(clcd_pkg::MODE_TICK, 8'h00);

		// Let the two pipeline stages settle after the last result.
		wait_drained();
		repeat (5) @(posedge clk);
		if (sb.pending() != 0)
			sb.report("expectations left over", 4'd0, 4'd0);

		$display("Run covered %0d transfers in, %0d results checked, %0d refused requests,",
			sb.n_in, sb.n_out, sb.n_rej);
		$display("and %0d complete power-up programs, with timings from zero to full scale.",
			sb.n_init_done);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
